// ----- sv/tmab_pkg.sv -----
`timescale 1ns / 1ps

package tmab_pkg;

   // Channel limits and rounding bias for the divide-by-255
   localparam logic [7:0]  CHANNEL_MAX = 8'd255;
   localparam logic [16:0] ROUND_BIAS  = 17'd128;

   // Shift values after reset
   localparam logic [4:0] RED_SHIFT_RESET   = 5'd16;
   localparam logic [4:0] GREEN_SHIFT_RESET = 5'd8;
   localparam logic [4:0] BLUE_SHIFT_RESET  = 5'd0;
   localparam logic [4:0] ALPHA_SHIFT_RESET = 5'd24;

   // Register index, taken from paddr[4:2]
   typedef enum logic [2:0] {
      REG_BLEND_ENABLE      = 3'd0,
      REG_ALPHA_TEST_ENABLE = 3'd1,
      REG_ALPHA_REFERENCE   = 3'd2,
      REG_RED_SHIFT         = 3'd3,
      REG_GREEN_SHIFT       = 3'd4,
      REG_BLUE_SHIFT        = 3'd5,
      REG_ALPHA_SHIFT       = 3'd6
   } reg_index_type;

   // Configuration seen by the pixel pipeline
   typedef struct packed {
      logic       blend_enable;
      logic       alpha_test_enable;
      logic [7:0] alpha_reference;
      logic [4:0] red_shift;
      logic [4:0] green_shift;
      logic [4:0] blue_shift;
      logic [4:0] alpha_shift;
   } cfg_type;

   // Rounded x / 255 for x up to 255*255
   function automatic logic [7:0] rdiv255(input logic [15:0] x);
      logic [16:0] y;
      logic [16:0] z;
      y = {1'b0, x} + ROUND_BIAS;
      z = y + (y >> 8);
      return z[15:8];
   endfunction

   // Byte of a word at a bit position; bits above 31 are lost
   function automatic logic [7:0] get_byte(input logic [31:0] word, input logic [4:0] sh);
      logic [31:0] t;
      t = word >> sh;
      return t[7:0];
   endfunction

   // Byte placed at a bit position; bits above 31 are lost
   function automatic logic [31:0] put_byte(input logic [7:0] v, input logic [4:0] sh);
      return {24'd0, v} << sh;
   endfunction

endpackage

// ----- sv/tmab_csr.sv -----
`timescale 1ns / 1ps

module tmab_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output tmab_pkg::cfg_type cfg
);
   import tmab_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_hit;

   assign pready    = 1'b1;
   assign index     = reg_index_type'(paddr[4:2]);
   assign write_hit = psel && penable && pwrite && pready;
   assign cfg       = cfg_ff;

   // Register write decode; addresses past the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (write_hit) begin
         unique case (index)
            REG_BLEND_ENABLE:      cfg_in.blend_enable      = pwdata[0];
            REG_ALPHA_TEST_ENABLE: cfg_in.alpha_test_enable = pwdata[0];
            REG_ALPHA_REFERENCE:   cfg_in.alpha_reference   = pwdata[7:0];
            REG_RED_SHIFT:         cfg_in.red_shift         = pwdata[4:0];
            REG_GREEN_SHIFT:       cfg_in.green_shift       = pwdata[4:0];
            REG_BLUE_SHIFT:        cfg_in.blue_shift        = pwdata[4:0];
            REG_ALPHA_SHIFT:       cfg_in.alpha_shift       = pwdata[4:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_enable      <= 1'b0;
         cfg_ff.alpha_test_enable <= 1'b0;
         cfg_ff.alpha_reference   <= 8'd0;
         cfg_ff.red_shift         <= RED_SHIFT_RESET;
         cfg_ff.green_shift       <= GREEN_SHIFT_RESET;
         cfg_ff.blue_shift        <= BLUE_SHIFT_RESET;
         cfg_ff.alpha_shift       <= ALPHA_SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      prdata = 32'd0;
      unique case (index)
         REG_BLEND_ENABLE:      prdata = {31'd0, cfg_ff.blend_enable};
         REG_ALPHA_TEST_ENABLE: prdata = {31'd0, cfg_ff.alpha_test_enable};
         REG_ALPHA_REFERENCE:   prdata = {24'd0, cfg_ff.alpha_reference};
         REG_RED_SHIFT:         prdata = {27'd0, cfg_ff.red_shift};
         REG_GREEN_SHIFT:       prdata = {27'd0, cfg_ff.green_shift};
         REG_BLUE_SHIFT:        prdata = {27'd0, cfg_ff.blue_shift};
         REG_ALPHA_SHIFT:       prdata = {27'd0, cfg_ff.alpha_shift};
         default:               prdata = 32'd0;
      endcase
   end

endmodule

// ----- sv/texel_modulate_alpha_blend.sv -----
`timescale 1ns / 1ps
// Per-fragment color unit: texel modulation, alpha test, source-over blend.
//
// Request channel: drive start high with the req_ fields for one cycle per
// fragment. busy is always low, so a request is taken at every edge where
// start is high; one fragment per clock is sustained indefinitely.
// Response channel: rsp_valid is high for exactly one cycle per request,
// with rsp_write_enable and rsp_pixel_out. A request passes the stage 1, 2
// and 3 registers and then the response registers before rsp_valid shows it.
// Responses come out in request order. The receiver cannot stall.
// The four pipeline stages are: modulation multiplies and destination byte
// extract, divide-by-255 and alpha test, blend multiply-add, then the
// final divide-by-255 and channel packing.
// Configuration: APB-style port, register i at byte address 4*i, pready
// always high. Registers must only change while no request is in flight.
// Reset (synchronous) clears all pipeline valid bits and restores the
// register defaults (blending and alpha test off, shifts 16/8/0/24).
module texel_modulate_alpha_blend (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_has_texel,
   input  logic [31:0] req_texel_word,
   input  logic [7:0]  req_colour_red,
   input  logic [7:0]  req_colour_green,
   input  logic [7:0]  req_colour_blue,
   input  logic [7:0]  req_colour_alpha,
   input  logic [31:0] req_dest_pixel,
   // response channel
   output logic        rsp_valid,
   output logic        rsp_write_enable,
   output logic [31:0] rsp_pixel_out,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tmab_pkg::*;

   cfg_type cfg;

   tmab_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage 1: modulation products, destination byte extract
   logic        s1_valid_ff;
   logic        s1_tex_ff;
   logic [15:0] s1_prod_ff [4];
   logic [7:0]  s1_col_ff  [4];
   logic [7:0]  s1_dst_ff  [3];
   logic [31:0] s1_dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_tex_ff     <= req_has_texel;
      s1_prod_ff[0] <= {8'd0, req_texel_word[7:0]}   * {8'd0, req_colour_red};
      s1_prod_ff[1] <= {8'd0, req_texel_word[15:8]}  * {8'd0, req_colour_green};
      s1_prod_ff[2] <= {8'd0, req_texel_word[23:16]} * {8'd0, req_colour_blue};
      s1_prod_ff[3] <= {8'd0, req_texel_word[31:24]} * {8'd0, req_colour_alpha};
      s1_col_ff[0]  <= req_colour_red;
      s1_col_ff[1]  <= req_colour_green;
      s1_col_ff[2]  <= req_colour_blue;
      s1_col_ff[3]  <= req_colour_alpha;
      s1_dst_ff[0]  <= get_byte(req_dest_pixel, cfg.red_shift);
      s1_dst_ff[1]  <= get_byte(req_dest_pixel, cfg.green_shift);
      s1_dst_ff[2]  <= get_byte(req_dest_pixel, cfg.blue_shift);
      s1_dest_ff    <= req_dest_pixel;
   end

   // Stage 2: source color, alpha test, blend decision
   logic        s2_valid_ff;
   logic        s2_drop_ff;
   logic        s2_drop_in;
   logic        s2_blend_ff;
   logic        s2_blend_in;
   logic [7:0]  s2_src_ff [4];
   logic [7:0]  s2_src_in [4];
   logic [7:0]  s2_dst_ff [3];
   logic [31:0] s2_dest_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s2_src_in[i] = s1_tex_ff ? rdiv255(s1_prod_ff[i]) : s1_col_ff[i];
      end
      s2_drop_in  = s1_tex_ff && cfg.alpha_test_enable
                    && (s2_src_in[3] == cfg.alpha_reference);
      s2_blend_in = cfg.blend_enable && (s2_src_in[3] != CHANNEL_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_drop_ff  <= s2_drop_in;
      s2_blend_ff <= s2_blend_in;
      s2_src_ff   <= s2_src_in;
      s2_dst_ff   <= s1_dst_ff;
      s2_dest_ff  <= s1_dest_ff;
   end

   // Stage 3: blend multiply-add; zero alpha under blending drops
   logic        s3_valid_ff;
   logic        s3_drop_ff;
   logic        s3_blend_ff;
   logic [7:0]  s3_src_ff [4];
   logic [15:0] s3_sum_ff [3];
   logic [31:0] s3_dest_ff;
   logic [7:0]  s3_inv_alpha;

   assign s3_inv_alpha = CHANNEL_MAX - s2_src_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_drop_ff  <= s2_drop_ff || (s2_blend_ff && (s2_src_ff[3] == 8'd0));
      s3_blend_ff <= s2_blend_ff;
      s3_src_ff   <= s2_src_ff;
      s3_dest_ff  <= s2_dest_ff;
      for (int i = 0; i < 3; i++) begin
         s3_sum_ff[i] <= {8'd0, s2_src_ff[i]} * {8'd0, s2_src_ff[3]}
                         + {8'd0, s2_dst_ff[i]} * {8'd0, s3_inv_alpha};
      end
   end

   // Stage 4: final divide, pack at the configured shifts
   logic        rsp_valid_ff;
   logic        rsp_write_enable_ff;
   logic [31:0] rsp_pixel_ff;
   logic [31:0] rsp_pixel_in;
   logic [7:0]  s4_chan [4];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_chan[i] = s3_blend_ff ? rdiv255(s3_sum_ff[i]) : s3_src_ff[i];
      end
      s4_chan[3] = s3_blend_ff ? CHANNEL_MAX : s3_src_ff[3];
      if (s3_drop_ff) begin
         rsp_pixel_in = s3_dest_ff;
      end else begin
         rsp_pixel_in = put_byte(s4_chan[0], cfg.red_shift)
                        | put_byte(s4_chan[1], cfg.green_shift)
                        | put_byte(s4_chan[2], cfg.blue_shift)
                        | put_byte(s4_chan[3], cfg.alpha_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_write_enable_ff <= !s3_drop_ff;
      rsp_pixel_ff        <= rsp_pixel_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_write_enable_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;

`ifndef ASSERT_OFF
   // every accepted request enters the pipe
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (s1_valid_ff == $past(accept)))
      else $error("accepted request did not enter stage 1");

   // valid bits advance one stage per clock, none lost or duplicated
   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff == $past(s1_valid_ff)) && (s3_valid_ff == $past(s2_valid_ff))
      && (rsp_valid == $past(s3_valid_ff)))
      else $error("pipeline valid bits out of step");

   // blending with zero source alpha must give a dropped response
   a_zero_alpha_drop: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_blend_ff && (s2_src_ff[3] == 8'd0))
      |=> ##1 (rsp_valid && !rsp_write_enable))
      else $error("zero alpha blend was written");
`endif

endmodule
